// ===== src/hfc_pkg.sv =====
`default_nettype none

package hfc_pkg;

	// Depth of the record queue between front and back
	localparam int QueueDepth = 4;

	// CRC-8, poly x^8+x^5+x^4+1, MSB first, no final xor
	localparam logic [7:0] CrcPoly = 8'h31;
	localparam logic [7:0] CrcInit = 8'hFF;

	// Conversion constants
	localparam logic [10:0] TempSpan   = 11'd1750;
	localparam logic [10:0] TempOffset = 11'd450;
	localparam logic [6:0]  HumSpan    = 7'd100;
	localparam logic [15:0] FullScale  = 16'hFFFF;

	localparam int OutWidth = 24;

	// Byte position within the six-byte reply
	typedef enum logic [2:0] {
		POS_T_HI  = 3'd0,
		POS_T_LO  = 3'd1,
		POS_T_CRC = 3'd2,
		POS_H_HI  = 3'd3,
		POS_H_LO  = 3'd4,
		POS_H_CRC = 3'd5
	} pos_t;

	// One checked reply, handed from front to back
	typedef struct packed {
		logic        temp_ok;
		logic        hum_ok;
		logic [15:0] raw_temp;
		logic [15:0] raw_hum;
	} hfc_rec_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== src/humidity_sensor_frame_checker_core.sv =====
// A reply's sixth byte queues a record; s1, s2 and the output register then carry its result.
// One byte per cycle while the record queue has room; tready drops only when it is full.
// Back end (multiply, divide by 65535, output register): one record per cycle while unstalled.
// Reset: arst_n low clears byte position, running CRC, queue and all valid flags at once;
// the first byte after reset counts as byte 0 of a reply even without a start mark.
`default_nettype none

module humidity_sensor_frame_checker_core
	import hfc_pkg::*;
#(
	parameter int QUEUE_DEPTH = QueueDepth
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input byte stream
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [7:0]           s_axis_tdata,   // [7:0] data_byte
	input  wire logic                 s_axis_tuser,   // [0] frame_start
	// result stream, one transfer per complete reply
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// [0] frame_ok, [1] temp_crc_ok, [2] hum_crc_ok, [14:3] temperature_tenths,
	// [21:15] humidity_percent, [23:22] zero
	output logic [OutWidth-1:0]       m_axis_tdata
);

	logic     byte_fire;
	logic     push;
	hfc_rec_t push_rec;
	logic     q_full;
	logic     q_not_empty;
	logic     q_pop;
	hfc_rec_t q_rec;

	// Ready ignores the byte contents; a byte transfer can push at most one record
	assign s_axis_tready = !q_full;
	assign byte_fire     = s_axis_tvalid && s_axis_tready;

	// Front: byte position, running CRC, raw word capture
	hfc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_fire   (byte_fire),
		.data_byte   (s_axis_tdata),
		.frame_start (s_axis_tuser),
		.push        (push),
		.push_rec    (push_rec)
	);

	// Queue of checked replies, lets the result side stall independently
	hfc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (q_pop),
		.pop_rec   (q_rec)
	);

	// Back: unit conversion and output register
	hfc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (q_not_empty),
		.rec       (q_rec),
		.rec_pop   (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

`default_nettype wire

// ===== src/hfc_front.sv =====
`default_nettype none

module hfc_front
	import hfc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_fire,
	input  wire logic [7:0] data_byte,
	input  wire logic       frame_start,
	output logic            push,
	output hfc_rec_t        push_rec
);

	pos_t        pos_q;
	logic [7:0]  crc_q;
	logic        temp_ok_q;
	logic [15:0] raw_temp_q;
	logic [15:0] raw_hum_q;

	pos_t       pos_eff;
	pos_t       pos_nxt;
	logic [7:0] crc_base;
	logic [7:0] crc_nxt;
	logic       crc_match;

	// a start mark restarts the frame on this very byte
	assign pos_eff   = frame_start ? POS_T_HI : pos_q;
	assign crc_base  = frame_start ? CrcInit : crc_q;
	assign crc_nxt   = crc8_byte(crc_base, data_byte);
	assign crc_match = (crc_base == data_byte);

	always_comb begin
		case (pos_eff)
			POS_T_HI:  pos_nxt = POS_T_LO;
			POS_T_LO:  pos_nxt = POS_T_CRC;
			POS_T_CRC: pos_nxt = POS_H_HI;
			POS_H_HI:  pos_nxt = POS_H_LO;
			POS_H_LO:  pos_nxt = POS_H_CRC;
			POS_H_CRC: pos_nxt = POS_T_HI;
			default:   pos_nxt = POS_T_LO;
		endcase
	end

	assign push     = byte_fire && (pos_eff == POS_H_CRC);
	assign push_rec = '{temp_ok: temp_ok_q, hum_ok: crc_match,
		raw_temp: raw_temp_q, raw_hum: raw_hum_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_T_HI;
			crc_q     <= CrcInit;
			temp_ok_q <= 1'b0;
		end else if (byte_fire) begin
			pos_q <= pos_nxt;
			case (pos_eff)
				POS_T_LO:  crc_q <= crc_nxt;
				POS_T_CRC: begin
					temp_ok_q <= crc_match;
					crc_q     <= CrcInit;
				end
				POS_H_HI:  crc_q <= crc_nxt;
				POS_H_LO:  crc_q <= crc_nxt;
				POS_H_CRC: crc_q <= CrcInit;
				default:   crc_q <= crc_nxt;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (byte_fire) begin
			case (pos_eff)
				POS_T_LO:  raw_temp_q[7:0] <= data_byte;
				POS_T_CRC: ;
				POS_H_HI:  raw_hum_q <= {data_byte, 8'h00};
				POS_H_LO:  raw_hum_q[7:0] <= data_byte;
				POS_H_CRC: ;
				default:   raw_temp_q <= {data_byte, 8'h00};
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/hfc_queue.sv =====
`default_nettype none

module hfc_queue
	import hfc_pkg::*;
#(
	parameter int DEPTH = QueueDepth
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  hfc_rec_t       push_rec,
	output logic           full,
	output logic           not_empty,
	input  wire logic      pop,
	output hfc_rec_t       pop_rec
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	hfc_rec_t        entry_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_rec   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_rec;
	end

endmodule

`default_nettype wire

// ===== src/hfc_back.sv =====
`default_nettype none

module hfc_back
	import hfc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                rec_valid,
	input  hfc_rec_t                 rec,
	output logic                     rec_pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [OutWidth-1:0]      out_data
);

	// s1: scaled raw words
	logic        v_s1;
	logic        tok_s1, hok_s1;
	logic [26:0] xt_s1;
	logic [22:0] xh_s1;
	// s2: quotients by 65535
	logic        v_s2;
	logic        tok_s2, hok_s2;
	logic [26:0] xt_s2;
	logic [10:0] qt_s2;
	logic [6:0]  qh_s2;
	// s3: output register
	logic        v_q;
	logic [OutWidth-1:0] data_q;

	logic en1, en2, en3;
	logic [26:0] sum_t;
	logic [22:0] sum_h;
	logic [26:0] prod_t;
	logic        rem_nz;
	logic        below_zero;
	logic        fok;
	logic [12:0] tval;
	logic [11:0] temp_out;
	logic [6:0]  hum_out;

	assign en3     = !v_q || out_ready;
	assign en2     = !v_s2 || en3;
	assign en1     = !v_s1 || en2;
	assign rec_pop = rec_valid && en1;

	// floor(x / 65535) = (x + (x >> 16) + 1) >> 16 for x below 2^32 - 1
	assign sum_t = xt_s1 + 27'(xt_s1[26:16]) + 27'd1;
	assign sum_h = xh_s1 + 23'(xh_s1[22:16]) + 23'd1;

	// truncation toward zero: negative results with a remainder round up
	assign prod_t     = 27'(qt_s2) * 27'(FullScale);
	assign rem_nz     = (xt_s2 != prod_t);
	assign below_zero = (qt_s2 < TempOffset);
	assign fok        = tok_s2 && hok_s2;
	assign tval       = 13'(qt_s2) - 13'(TempOffset) + 13'(rem_nz && below_zero);
	assign temp_out   = fok ? tval[11:0] : '0;
	assign hum_out    = fok ? qh_s2 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (en1) v_s1 <= rec_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_q  <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_pop) begin
			tok_s1 <= rec.temp_ok;
			hok_s1 <= rec.hum_ok;
			xt_s1  <= 27'(TempSpan) * 27'(rec.raw_temp);
			xh_s1  <= 23'(HumSpan) * 23'(rec.raw_hum);
		end
		if (en2 && v_s1) begin
			tok_s2 <= tok_s1;
			hok_s2 <= hok_s1;
			xt_s2  <= xt_s1;
			qt_s2  <= sum_t[26:16];
			qh_s2  <= sum_h[22:16];
		end
		if (en3 && v_s2) begin
			data_q <= {2'b00, hum_out, temp_out, hok_s2, tok_s2, fok};
		end
	end

	assign out_valid = v_q;
	assign out_data  = data_q;

endmodule

`default_nettype wire

// ===== src/hfc_checker.sv =====
`default_nettype none

module hfc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [7:0]  s_axis_tdata,
	input wire logic        s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [23:0] m_axis_tdata
);

	// no result is offered while in reset (from the second reset cycle on)
	a_rst_quiet: assert property (@(posedge clk) !arst_n && $past(!arst_n) |-> !m_axis_tvalid)
		else $error("result valid during reset");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// overall verdict is the AND of both CRC verdicts
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[0] == (m_axis_tdata[1] && m_axis_tdata[2]))
		else $error("frame_ok inconsistent");

	// a bad frame reports zero readings
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[23:3] == 21'd0)
		else $error("bad frame carries readings");

	// humidity never exceeds full scale
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[21:15] <= 7'd100 && m_axis_tdata[23:22] == 2'b00)
		else $error("humidity out of range");

endmodule

bind humidity_sensor_frame_checker_core hfc_checker u_hfc_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

// Tracks the reply framing of the humidity sensor checker and keeps the readings
// that the result stream still owes, oldest first.
class frame_scoreboard;
	typedef struct {
		bit              frame_ok;
		bit              temp_ok;
		bit              hum_ok;
		bit signed [11:0] tenths;
		bit [6:0]        percent;
	} reading_t;

	reading_t        owed_q[$];
	hfc_pkg::pos_t   pos;
	bit [7:0]        crc;
	bit [15:0]       raw_temp;
	bit [15:0]       raw_hum;
	bit              temp_passed;

	int errors;
	int bytes_seen;
	int readings_seen;
	int good_frames;
	int bad_temp_frames;
	int bad_hum_frames;

	function new();
		pos = hfc_pkg::POS_T_HI;
		crc = hfc_pkg::CrcInit;
		raw_temp = '0;
		raw_hum = '0;
		temp_passed = 1'b0;
	endfunction

	// bit-serial form of the CRC-8: shift in one data bit at a time, MSB first
	static function bit [7:0] crc_step(bit [7:0] c, bit [7:0] d);
		bit fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ d[i];
			c = {c[6:0], 1'b0};
			if (fb)
				c = c ^ hfc_pkg::CrcPoly;
		end
		return c;
	endfunction

	static function bit [7:0] word_crc(bit [15:0] w);
		return crc_step(crc_step(hfc_pkg::CrcInit, w[15:8]), w[7:0]);
	endfunction

	function int pending();
		return owed_q.size();
	endfunction

	task report(string msg);
		$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	// one byte transfer into the block
	function void note_byte(bit [7:0] d, bit mark);
		reading_t r;
		int       n;
		bytes_seen++;
		if (mark) begin
			pos = hfc_pkg::POS_T_HI;
			crc = hfc_pkg::CrcInit;
		end
		case (pos)
			hfc_pkg::POS_T_HI: begin
				crc = crc_step(crc, d);
				raw_temp = {d, 8'h00};
			end
			hfc_pkg::POS_T_LO: begin
				crc = crc_step(crc, d);
				raw_temp[7:0] = d;
			end
			hfc_pkg::POS_T_CRC: begin
				temp_passed = (crc == d);
				crc = hfc_pkg::CrcInit;
			end
			hfc_pkg::POS_H_HI: begin
				crc = crc_step(crc, d);
				raw_hum = {d, 8'h00};
			end
			hfc_pkg::POS_H_LO: begin
				crc = crc_step(crc, d);
				raw_hum[7:0] = d;
			end
			default: begin
				r.temp_ok = temp_passed;
				r.hum_ok = (crc == d);
				r.frame_ok = r.temp_ok & r.hum_ok;
				r.tenths = '0;
				r.percent = '0;
				if (r.frame_ok) begin
					// signed division truncates toward zero
					n = int'(hfc_pkg::TempSpan) * int'(raw_temp)
						- int'(hfc_pkg::TempOffset) * int'(hfc_pkg::FullScale);
					r.tenths = 12'(n / int'(hfc_pkg::FullScale));
					r.percent = 7'((int'(hfc_pkg::HumSpan) * int'(raw_hum))
						/ int'(hfc_pkg::FullScale));
				end
				owed_q.push_back(r);
				crc = hfc_pkg::CrcInit;
			end
		endcase
		pos = (pos == hfc_pkg::POS_H_CRC) ? hfc_pkg::POS_T_HI : hfc_pkg::pos_t'(pos + 3'd1);
	endfunction

	// one result transfer out of the block
	task check_reading(logic [hfc_pkg::OutWidth-1:0] w);
		reading_t r;
		readings_seen++;
		if (owed_q.size() == 0) begin
			report($sformatf("unexpected result 0x%06h", w));
		end else begin
			r = owed_q.pop_front();
			if (r.frame_ok)
				good_frames++;
			if (!r.temp_ok)
				bad_temp_frames++;
			if (!r.hum_ok)
				bad_hum_frames++;
			if (w[0] !== r.frame_ok)
				report($sformatf("frame_ok got %b want %b", w[0], r.frame_ok));
			if (w[1] !== r.temp_ok)
				report($sformatf("temp_crc_ok got %b want %b", w[1], r.temp_ok));
			if (w[2] !== r.hum_ok)
				report($sformatf("hum_crc_ok got %b want %b", w[2], r.hum_ok));
			if (w[14:3] !== r.tenths)
				report($sformatf("temperature_tenths got %0d want %0d",
					$signed(w[14:3]), r.tenths));
			if (w[21:15] !== r.percent)
				report($sformatf("humidity_percent got %0d want %0d", w[21:15], r.percent));
			if (w[23:22] !== 2'b00)
				report($sformatf("pad bits got %b", w[23:22]));
		end
	endtask
endclass

module tb;
	localparam int StallLimit = 1000;   // cycles without any transfer
	localparam int HoldCycles = 150;    // long output hold-off
	localparam int ByteTarget = 450;
	localparam int QuietAfter = 380;    // no idling past this many bytes
	localparam int DrainCycles = 12;

	logic                           clk;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [7:0]                     s_axis_tdata;   // [7:0] data_byte
	logic                           s_axis_tuser;   // [0] frame_start
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	// [0] frame_ok, [1] temp_crc_ok, [2] hum_crc_ok, [14:3] temperature_tenths,
	// [21:15] humidity_percent, [23:22] zero
	logic [hfc_pkg::OutWidth-1:0]   m_axis_tdata;

	frame_scoreboard sb = new();
	int  bytes_sent = 0;
	int  idle_count = 0;
	bit  quiet = 1'b0;
	bit  held = 1'b0;

	humidity_sensor_frame_checker_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// monitor and watchdog, both sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_byte(s_axis_tdata, s_axis_tuser);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_reading(m_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_count <= 0;
			else
				idle_count <= idle_count + 1;
			if (idle_count >= StallLimit) begin
				$display("watchdog: no transfer for %0d cycles", StallLimit);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// result side: random stall bursts, one long hold-off while the sender keeps going
	initial begin
		int n;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && bytes_sent >= 150) begin
				m_axis_tready <= 1'b0;
				n = HoldCycles;
				held = 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				n = $urandom_range(1, 11);
			end else begin
				m_axis_tready <= 1'b1;
				n = $urandom_range(1, 20);
			end
			repeat (n - 1) @(negedge clk);
		end
	end

	// one byte transfer, with an optional gap in front of it
	task send_byte(bit [7:0] d, bit mark);
		int gap;
		gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 11) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tuser <= mark;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
		if (bytes_sent >= QuietAfter)
			quiet = 1'b1;
	endtask

	// first 'len' bytes of a reply; a corrupted CRC byte is flipped by a nonzero mask
	task send_frame(bit [15:0] rt, bit [15:0] rh, bit mark, bit bad_t, bit bad_h, int len);
		bit [7:0] b [6];
		b[0] = rt[15:8];
		b[1] = rt[7:0];
		b[2] = sb.word_crc(rt) ^ (bad_t ? 8'($urandom_range(1, 255)) : 8'h00);
		b[3] = rh[15:8];
		b[4] = rh[7:0];
		b[5] = sb.word_crc(rh) ^ (bad_h ? 8'($urandom_range(1, 255)) : 8'h00);
		for (int i = 0; i < len; i++)
			send_byte(b[i], (i == 0) ? mark : 1'b0);
	endtask

	function bit [15:0] pick_raw();
		case ($urandom_range(0, 7))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int kind;
		int len;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reply right after reset without a start mark, scale extremes,
		// a reply cut off by a new start mark, each CRC broken alone
		send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0, 6);
		send_frame(16'hFFFF, 16'h0000, 1'b1, 1'b0, 1'b0, 6);
		send_frame(16'h1234, 16'h5678, 1'b1, 1'b0, 1'b0, 2);
		send_frame(16'h0001, 16'h8000, 1'b1, 1'b1, 1'b0, 6);
		send_frame(16'h7FFF, 16'hFFFE, 1'b1, 1'b0, 1'b1, 6);

		// random: mostly well-formed replies, some unmarked, cut short or plain noise
		while (bytes_sent < ByteTarget) begin
			kind = $urandom_range(0, 19);
			if (kind < 13) begin
				send_frame(pick_raw(), pick_raw(), 1'b1, $urandom_range(0, 7) == 0,
					$urandom_range(0, 7) == 0, 6);
			end else if (kind < 15) begin
				send_frame(pick_raw(), pick_raw(), 1'b0, 1'b0, 1'b0, 6);
			end else if (kind < 17) begin
				send_frame(pick_raw(), pick_raw(), 1'b1, 1'b0, 1'b0, $urandom_range(1, 5));
			end else begin
				len = $urandom_range(1, 8);
				repeat (len)
					send_byte(8'($urandom), $urandom_range(0, 3) == 0);
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("%0d bytes in, %0d readings out: %0d ok, %0d bad temp CRC, %0d bad humidity CRC",
			sb.bytes_seen, sb.readings_seen, sb.good_frames, sb.bad_temp_frames,
			sb.bad_hum_frames);
		$display("covered unmarked and cut-off replies, noise, stalls and one long output hold");
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
